[design/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants for the text console writer: screen geometry, cell
// layout and character codes.
// ----------------------------------------------------------------------------
package tcw_pkg;

	localparam int ROWS     = 25;
	localparam int COLS     = 80;
	localparam int CELLS    = ROWS * COLS;
	localparam int ADDR_W   = $clog2(CELLS);
	localparam int ROW_W    = $clog2(ROWS);
	localparam int COL_W    = $clog2(COLS);
	localparam int CELL_W   = 16;
	localparam int CURSOR_W = 11;

	localparam logic [7:0] NEWLINE_CODE = 8'h0A;
	localparam logic [7:0] BLANK_CHAR   = 8'h20;
	localparam logic [7:0] RESET_ATTR   = 8'h07;

endpackage

[design/tcw_ram.sv]
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/text_console_writer_core.sv]
// ----------------------------------------------------------------------------
// text_console_writer_core
// Character-cell text console: cell store, cursor, newline, wrap and scroll.
// ----------------------------------------------------------------------------
// Usage: an item is taken on a clock edge with start high and busy low.
// Each item gives exactly one result, shown for one cycle with done high;
// the receiver cannot stall it, so sample on done. A plain put gives its
// result in the next cycle, a newline without scroll likewise; a read
// passes the registered read port of the cell RAM and then the result
// register. A put that runs off the last row scrolls the screen: one pass
// over the whole store through the single RAM write port, with busy high
// until the result. After reset the store is swept to blanks (attribute
// 0x07) with busy high. The attribute register can be written at any time
// over cfg_valid/cfg_ready (always ready), but must only change while no
// item is in flight.
// ----------------------------------------------------------------------------
module text_console_writer_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// item channel
	input  logic                         start,
	output logic                         busy,
	input  logic                         action,
	input  logic [7:0]                   char_code,
	input  logic [4:0]                   read_row,
	input  logic [6:0]                   read_col,
	// result channel
	output logic                         done,
	output logic [tcw_pkg::CURSOR_W-1:0] cursor_position,
	output logic [tcw_pkg::CELL_W-1:0]   cell_value,
	output logic                         scrolled,
	// attribute register write
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [7:0]                   cfg_data
);

	import tcw_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,   // post-reset sweep to blanks
		ST_IDLE,
		ST_READ,    // RAM read in flight
		ST_SCROLL,  // copy rows up, then blank the bottom row
		ST_DRAIN    // last scroll write
	} state_t;

	localparam logic [ADDR_W-1:0] LAST_CELL     = ADDR_W'(CELLS - 1);
	localparam logic [ADDR_W-1:0] COPY_END      = ADDR_W'(CELLS - COLS);
	localparam logic [ADDR_W-1:0] ROW_STEP      = ADDR_W'(COLS);
	localparam logic [ADDR_W-1:0] LAST_ROW_POS  = ADDR_W'((ROWS - 1) * COLS);
	localparam logic [ROW_W-1:0]  LAST_ROW      = ROW_W'(ROWS - 1);
	localparam logic [COL_W-1:0]  LAST_COL      = COL_W'(COLS - 1);

	state_t             state_q;
	logic [ADDR_W-1:0]  cnt_q;      // sweep counter (clear and scroll)
	logic [ADDR_W-1:0]  pos_q;      // linear cursor index
	logic [ROW_W-1:0]   row_q;
	logic [COL_W-1:0]   col_q;
	logic [7:0]         attr_q;

	// scroll write stage
	logic               wr_s1;
	logic               blank_s1;
	logic [ADDR_W-1:0]  waddr_s1;

	logic               rd_ok_s1;   // read address was on screen

	logic               done_q;
	logic               scrolled_q;
	logic [CELL_W-1:0]  cell_q;

	// RAM port signals
	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic [CELL_W-1:0]  ram_wdata;
	logic               ram_re;
	logic [ADDR_W-1:0]  ram_raddr;
	logic [CELL_W-1:0]  ram_rdata;

	logic               accept;
	logic               put_char;
	logic               is_nl;
	logic               at_last_col;
	logic               at_last_row;
	logic               overflow;
	logic               in_range;
	logic [ADDR_W-1:0]  rd_addr;
	logic               is_copy;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	assign is_nl       = (char_code == NEWLINE_CODE);
	assign put_char    = accept && !action && !is_nl;
	assign at_last_col = (col_q == LAST_COL);
	assign at_last_row = (row_q == LAST_ROW);
	// cursor leaves the last row on a newline there, or on a wrap there
	assign overflow    = at_last_row && (is_nl || at_last_col);

	assign in_range = (32'(read_row) < ROWS) && (32'(read_col) < COLS);
	assign rd_addr  = ADDR_W'(32'(read_row) * COLS + 32'(read_col));
	assign is_copy  = (cnt_q < COPY_END);

	// Read port: scroll source row, else the requested cell.
	always_comb begin
		if (state_q == ST_SCROLL) begin
			ram_re    = is_copy;
			ram_raddr = cnt_q + ROW_STEP;
		end else begin
			ram_re    = accept && action;
			ram_raddr = rd_addr;
		end
	end

	// Write port: clear sweep, scroll stage, or a put at the cursor.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = cnt_q;
			ram_wdata = {RESET_ATTR, BLANK_CHAR};
		end else if (wr_s1) begin
			ram_we    = 1'b1;
			ram_waddr = waddr_s1;
			ram_wdata = blank_s1 ? {attr_q, BLANK_CHAR} : ram_rdata;
		end else begin
			ram_we    = put_char;
			ram_waddr = pos_q;
			ram_wdata = {attr_q, char_code};
		end
	end

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELLS)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (cfg_valid && cfg_ready) begin
			attr_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			cnt_q      <= '0;
			pos_q      <= '0;
			row_q      <= '0;
			col_q      <= '0;
			wr_s1      <= 1'b0;
			blank_s1   <= 1'b0;
			waddr_s1   <= '0;
			rd_ok_s1   <= 1'b0;
			done_q     <= 1'b0;
			scrolled_q <= 1'b0;
			cell_q     <= '0;
		end else begin
			done_q <= 1'b0;
			wr_s1  <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q == LAST_CELL) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && action) begin
						rd_ok_s1 <= in_range;
						state_q  <= ST_READ;
					end else if (accept) begin
						// put: move the cursor
						if (is_nl || at_last_col) begin
							col_q <= '0;
							if (overflow) begin
								row_q <= LAST_ROW;
								pos_q <= LAST_ROW_POS;
							end else begin
								row_q <= row_q + ROW_W'(1);
								pos_q <= is_nl ? pos_q + ROW_STEP - ADDR_W'(col_q)
								               : pos_q + ADDR_W'(1);
							end
						end else begin
							col_q <= col_q + COL_W'(1);
							pos_q <= pos_q + ADDR_W'(1);
						end
						if (overflow) begin
							cnt_q   <= '0;
							state_q <= ST_SCROLL;
						end else begin
							done_q     <= 1'b1;
							scrolled_q <= 1'b0;
							cell_q     <= '0;
						end
					end
				end
				ST_READ: begin
					done_q     <= 1'b1;
					scrolled_q <= 1'b0;
					cell_q     <= rd_ok_s1 ? ram_rdata : '0;
					state_q    <= ST_IDLE;
				end
				ST_SCROLL: begin
					// read cell cnt+COLS now, write it to cnt next cycle;
					// bottom row takes blanks with no read
					wr_s1    <= 1'b1;
					blank_s1 <= !is_copy;
					waddr_s1 <= cnt_q;
					cnt_q    <= cnt_q + ADDR_W'(1);
					if (cnt_q == LAST_CELL) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					done_q     <= 1'b1;
					scrolled_q <= 1'b1;
					cell_q     <= '0;
					state_q    <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done            = done_q;
	assign scrolled        = scrolled_q;
	assign cell_value      = cell_q;
	assign cursor_position = CURSOR_W'(pos_q);

`ifndef SYNTHESIS
	a_read_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action) |-> ##2 done)
		else $error("read result not delivered two cycles after transfer");

	a_scroll_has_no_cell: assert property (@(posedge clk) disable iff (!arst_n)
		(done && scrolled) |-> (cell_value == '0))
		else $error("scroll result carries cell data");

	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(pos_q <= LAST_CELL) && (row_q <= LAST_ROW) && (col_q <= LAST_COL))
		else $error("cursor off screen");

	a_no_result_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR || state_q == ST_SCROLL) |-> !done)
		else $error("result strobe during a store sweep");

	a_scroll_ends_on_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |=> (pos_q == LAST_ROW_POS && col_q == '0))
		else $error("cursor not at start of last row after scroll");
`endif

endmodule

[bench/tb_text_console_writer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer_core
// Self-checking bench for the text console writer. A scoreboard keeps its
// own copy of the screen, the cursor and the attribute, and predicts the
// result of every accepted item. A directed part covers the field extremes,
// off-screen reads and newline, then random phases mix puts, newlines and
// reads under several attribute settings, so that wraps and scrolls occur.
// ----------------------------------------------------------------------------
module tb_text_console_writer_core;

	import tcw_pkg::*;

	// item kinds on the action input
	localparam logic ACT_PUT  = 1'b0;
	localparam logic ACT_READ = 1'b1;

	localparam int PHASES       = 6;
	localparam int PHASE_ITEMS  = 100;
	localparam int MAX_REPORTS  = 10;
	// clock period is 12 ns
	localparam longint RUN_LIMIT_NS = 64'd60_000_000;

	// ------------------------------------------------------------------------
	// Scoreboard: screen model, cursor, attribute and pending results
	// ------------------------------------------------------------------------
	class console_scoreboard;
		typedef struct {
			logic [CURSOR_W-1:0] cursor_position;
			logic [CELL_W-1:0]   cell_value;
			logic                scrolled;
		} console_result_t;

		logic [CELL_W-1:0] screen [CELLS];
		int unsigned       cur_row;
		int unsigned       cur_col;
		logic [7:0]        attr;
		console_result_t   pending_q [$];

		int unsigned errors;
		int unsigned checked;
		int unsigned puts;
		int unsigned newlines;
		int unsigned reads;
		int unsigned scrolls;

		function new();
			foreach (screen[i]) screen[i] = {RESET_ATTR, BLANK_CHAR};
			cur_row  = 0;
			cur_col  = 0;
			attr     = RESET_ATTR;
			errors   = 0;
			checked  = 0;
			puts     = 0;
			newlines = 0;
			reads    = 0;
			scrolls  = 0;
		endfunction

		function void set_attribute(input logic [7:0] value);
			attr = value;
		endfunction

		function int pending();
			return pending_q.size();
		endfunction

		// predict the result of one accepted item
		function void note_item(input logic act, input logic [7:0] code,
				input logic [4:0] rrow, input logic [6:0] rcol);
			console_result_t res;
			res.cell_value = '0;
			res.scrolled   = 1'b0;
			if (act == ACT_READ) begin
				reads++;
				// off-screen reads give a zero cell
				if (int'(rrow) < ROWS && int'(rcol) < COLS)
					res.cell_value = screen[int'(rrow) * COLS + int'(rcol)];
			end else begin
				if (code == NEWLINE_CODE) begin
					newlines++;
					cur_col = 0;
					cur_row++;
				end else begin
					puts++;
					screen[cur_row * COLS + cur_col] = {attr, code};
					cur_col++;
					if (cur_col >= COLS) begin
						cur_col = 0;
						cur_row++;
					end
				end
				if (cur_row >= ROWS) begin
					// move every row up, bottom row blank in current attribute
					for (int i = 0; i + COLS < CELLS; i++)
						screen[i] = screen[i + COLS];
					for (int i = (ROWS - 1) * COLS; i < CELLS; i++)
						screen[i] = {attr, BLANK_CHAR};
					cur_row      = ROWS - 1;
					res.scrolled = 1'b1;
					scrolls++;
				end
			end
			res.cursor_position = CURSOR_W'(cur_row * COLS + cur_col);
			pending_q.push_back(res);
		endfunction

		// compare one result strobe with the oldest prediction
		function void check_result(input logic [CURSOR_W-1:0] pos,
				input logic [CELL_W-1:0] cval, input logic scr);
			console_result_t exp_res;
			if (pending_q.size() == 0) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: unexpected result pos=%0d cell=%h scrolled=%b",
						$realtime, pos, cval, scr);
				return;
			end
			exp_res = pending_q.pop_front();
			checked++;
			if (pos !== exp_res.cursor_position || cval !== exp_res.cell_value ||
					scr !== exp_res.scrolled) begin
				errors++;
				if (errors <= MAX_REPORTS)
					$display("%0t: mismatch pos exp %0d got %0d, cell exp %h got %h, scrolled exp %b got %b",
						$realtime, exp_res.cursor_position, pos,
						exp_res.cell_value, cval, exp_res.scrolled, scr);
			end
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// DUT signals; every input known from time zero
	// ------------------------------------------------------------------------
	logic                clk;
	logic                arst_n    = 1'b0;
	logic                start     = 1'b0;
	logic                busy;
	logic                action    = ACT_PUT;
	logic [7:0]          char_code = '0;
	logic [4:0]          read_row  = '0;
	logic [6:0]          read_col  = '0;
	logic                done;
	logic [CURSOR_W-1:0] cursor_position;
	logic [CELL_W-1:0]   cell_value;
	logic                scrolled;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [7:0]          cfg_data  = '0;

	console_scoreboard sb = new();
	int unsigned       cfg_writes = 0;
	int unsigned       quiet_left = 0;

	text_console_writer_core u_top (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.action          (action),
		.char_code       (char_code),
		.read_row        (read_row),
		.read_col        (read_col),
		.done            (done),
		.cursor_position (cursor_position),
		.cell_value      (cell_value),
		.scrolled        (scrolled),
		.cfg_valid       (cfg_valid),
		.cfg_ready       (cfg_ready),
		.cfg_data        (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// results are strobed for one cycle; sample pre-edge values at the edge
	always @(posedge clk) begin
		if (arst_n && done)
			sb.check_result(cursor_position, cell_value, scrolled);
	end

	// ------------------------------------------------------------------------
	// Drivers. Each task is entered right after a rising edge and returns
	// right after the edge of its transfer.
	// ------------------------------------------------------------------------

	// sender gap drawn at random, with occasional stretches of back-to-back items
	function automatic int unsigned draw_gap();
		if (quiet_left > 0) begin
			quiet_left--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			quiet_left = $urandom_range(5, 20);
		return $urandom_range(0, 3);
	endfunction

	task automatic drive_item(input logic act, input logic [7:0] code,
			input logic [4:0] rrow, input logic [6:0] rcol);
		int unsigned gap;
		gap = draw_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		// start stays high across back-to-back items: one assignment per step
		start     <= 1'b1;
		action    <= act;
		char_code <= code;
		read_row  <= rrow;
		read_col  <= rcol;
		do @(posedge clk); while (busy);
		sb.note_item(act, code, rrow, rcol);
	endtask

	// drain all results, then let the block settle before touching the register
	task automatic drain;
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_attribute(input logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.set_attribute(value);
		cfg_writes++;
		cfg_valid <= 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------------
	initial begin
		logic [7:0]  phase_attr [PHASES];
		int unsigned phase_nl   [PHASES];
		int unsigned pick;
		logic [7:0]  code;

		// attribute per phase, extremes included; newline weight per phase,
		// zero in some phases so that long runs wrap and scroll at row end
		phase_attr = '{8'h00, 8'hFF, 8'h00, 8'h80, 8'hFF, 8'h07};
		phase_attr[2] = 8'($urandom_range(0, 255));
		phase_attr[4] = 8'($urandom_range(0, 255));
		phase_nl   = '{25, 25, 0, 10, 25, 0};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// wait out the store sweep after reset
		do @(posedge clk); while (busy);

		// ---- directed: blank screen, corners and off-screen reads
		drive_item(ACT_READ, 8'h00, 5'd0,  7'd0);
		drive_item(ACT_READ, 8'hFF, 5'd24, 7'd79);
		drive_item(ACT_READ, 8'h00, 5'd25, 7'd0);
		drive_item(ACT_READ, 8'h00, 5'd31, 7'd127);
		drive_item(ACT_READ, 8'h00, 5'd0,  7'd80);
		drive_item(ACT_READ, 8'h00, 5'd3,  7'd127);
		// ---- directed: character extremes and newline with reset attribute
		drive_item(ACT_PUT,  8'h48, 5'd31, 7'd127);
		drive_item(ACT_PUT,  8'h00, 5'd0,  7'd0);
		drive_item(ACT_PUT,  8'hFF, 5'd0,  7'd0);
		drive_item(ACT_PUT,  NEWLINE_CODE, 5'd0, 7'd0);
		drive_item(ACT_PUT,  8'h7E, 5'd0,  7'd0);
		drive_item(ACT_READ, 8'h00, 5'd0,  7'd0);
		drive_item(ACT_READ, 8'h00, 5'd0,  7'd1);
		drive_item(ACT_READ, 8'h00, 5'd0,  7'd2);
		drive_item(ACT_READ, 8'h00, 5'd1,  7'd0);
		drive_item(ACT_READ, 8'h00, 5'd0,  7'd3);
		// ---- directed: attribute extremes reach the cells
		drain();
		write_attribute(8'h00);
		drive_item(ACT_PUT,  8'h78, 5'd0,  7'd0);
		drive_item(ACT_PUT,  NEWLINE_CODE, 5'd0, 7'd0);
		drive_item(ACT_READ, 8'h00, 5'd1,  7'd1);
		drain();
		write_attribute(8'hFF);
		drive_item(ACT_PUT,  8'h41, 5'd0,  7'd0);
		drive_item(ACT_READ, 8'h00, 5'd2,  7'd0);

		// ---- random phases
		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			write_attribute(phase_attr[ph]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pick = $urandom_range(0, 99);
				if (pick < phase_nl[ph]) begin
					drive_item(ACT_PUT, NEWLINE_CODE, 5'($urandom), 7'($urandom));
				end else if (pick < phase_nl[ph] + 50) begin
					code = 8'($urandom_range(0, 255));
					// a random 10 is a newline too, which is fine
					drive_item(ACT_PUT, code, 5'($urandom), 7'($urandom));
				end else if (pick < 90) begin
					drive_item(ACT_READ, 8'($urandom),
						5'($urandom_range(0, ROWS - 1)), 7'($urandom_range(0, COLS - 1)));
				end else begin
					// any row and column the fields allow, often off screen
					drive_item(ACT_READ, 8'($urandom), 5'($urandom), 7'($urandom));
				end
			end
		end

		// ---- wind down: all results in, then a scroll's worth of quiet
		start <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (CELLS + 20) @(posedge clk);

		$display("Covered %0d puts, %0d newlines, %0d reads, %0d scrolls, %0d attribute writes",
			sb.puts, sb.newlines, sb.reads, sb.scrolls, cfg_writes);
		$display("Checked %0d results, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

	// hang guard
	initial begin
		#(RUN_LIMIT_NS);
		$display("Timeout with %0d results outstanding", sb.pending());
		$display("TB_ERROR");
		$finish;
	end

endmodule
